// ===== hw/rtl/cpfe_pkg.sv =====
// Shared types and constants of the pairwise Coulomb force and energy block.
package cpfe_pkg;

  // Default number of particle slots
  localparam int unsigned PARTICLES_MAX_DEF = 1024;

  // Command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Signed 64-bit limits
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  // Divider widths: numerator is |q_i q_j| |d| << 16, denominator r^3
  localparam int unsigned DIV_NW = 112;
  localparam int unsigned DIV_DW = 99;

  // Command beat
  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         index;
    logic signed [31:0] charge;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic signed [63:0] force_z;
    logic signed [63:0] energy;
    logic               flagged;
  } res_t;

  // One stored particle
  typedef struct packed {
    logic signed [31:0] charge;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } part_t;

  // Outcome of one pair: signed force on i, energy term, skip and clamp flags
  typedef struct packed {
    logic [63:0] force_x;
    logic [63:0] force_y;
    logic [63:0] force_z;
    logic [63:0] energy;
    logic        skip;
    logic        sat;
  } pair_res_t;

endpackage

// ===== hw/rtl/cpfe_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module cpfe_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cpfe_pkg::DIV_NW-1:0] num_i,
  input  logic [cpfe_pkg::DIV_DW-1:0] den_i,
  output logic                        done_o,
  output logic [cpfe_pkg::DIV_NW-1:0] quo_o
);

  localparam int unsigned NW = cpfe_pkg::DIV_NW;
  localparam int unsigned DW = cpfe_pkg::DIV_DW;
  localparam int unsigned CW = $clog2(NW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] n_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_s;
  logic [DW:0]   rem_n;
  logic          ge;

  // One trial subtraction
  always_comb begin
    rem_s = {rem_q, n_q[NW-1]};
    ge    = rem_s >= {1'b0, den_q};
    rem_n = ge ? rem_s - {1'b0, den_q} : rem_s;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      n_q   <= {n_q[NW-2:0], ge};
      rem_q <= rem_n[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

// ===== hw/rtl/cpfe_pair.sv =====
// Force and energy of one particle pair on a shared 33x33 multiplier.
module cpfe_pair (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cpfe_pkg::part_t     pi_i,
  input  cpfe_pkg::part_t     pj_i,
  output logic                done_o,
  output cpfe_pkg::pair_res_t res_o
);

  localparam logic [5:0] SQRT_STEPS = 6'd33;

  typedef enum logic [2:0] {
    P_IDLE, P_MULA, P_CHK, P_SQRT, P_MULB, P_MULN, P_DIVF, P_DIVE
  } pstate_e;

  pstate_e             state_q;
  logic [5:0]          cnt_q;
  logic [1:0]          k_q;
  logic                done_q;
  cpfe_pkg::pair_res_t res_q;

  logic [31:0]       qa_q, qb_q;
  logic [2:0][32:0]  ad_q;
  logic [2:0]        dneg_q;
  logic              neg_q_q;
  logic [62:0]       mq_q;
  logic [65:0]       d2_q;
  logic [65:0]       sv_q;
  logic [35:0]       srem_q;
  logic [32:0]       r_q;
  logic [65:0]       r2_q;
  logic [98:0]       r3_q;
  logic [95:0]       num_q;
  logic [65:0]       mul_p_q;

  logic [32:0] mul_a, mul_b;
  logic [32:0] dx, dy, dz;
  logic [31:0] qa_abs, qb_abs;
  logic [37:0] srem_s, strial, srem_n;
  logic        sge;

  logic                        div_start, div_done;
  logic [cpfe_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [cpfe_pkg::DIV_DW-1:0] div_den;
  logic [63:0]                 fmag, fval, emag;
  logic                        fovf;

  // Operand magnitudes at start
  always_comb begin
    dx     = {pi_i.pos_x[31], pi_i.pos_x} - {pj_i.pos_x[31], pj_i.pos_x};
    dy     = {pi_i.pos_y[31], pi_i.pos_y} - {pj_i.pos_y[31], pj_i.pos_y};
    dz     = {pi_i.pos_z[31], pi_i.pos_z} - {pj_i.pos_z[31], pj_i.pos_z};
    qa_abs = pi_i.charge[31] ? 32'(-pi_i.charge) : 32'(pi_i.charge);
    qb_abs = pj_i.charge[31] ? 32'(-pj_i.charge) : 32'(pj_i.charge);
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      P_MULA: begin
        case (cnt_q)
          6'd0: begin mul_a = {1'b0, qa_q}; mul_b = {1'b0, qb_q}; end
          6'd1: begin mul_a = ad_q[0]; mul_b = ad_q[0]; end
          6'd2: begin mul_a = ad_q[1]; mul_b = ad_q[1]; end
          6'd3: begin mul_a = ad_q[2]; mul_b = ad_q[2]; end
          default: ;
        endcase
      end
      P_MULB: begin
        case (cnt_q)
          6'd0: begin mul_a = r_q; mul_b = r_q; end
          6'd2: begin mul_a = r2_q[32:0]; mul_b = r_q; end
          6'd3: begin mul_a = r2_q[65:33]; mul_b = r_q; end
          default: ;
        endcase
      end
      P_MULN: begin
        case (cnt_q)
          6'd0: begin mul_a = mq_q[32:0]; mul_b = ad_q[k_q]; end
          6'd1: begin mul_a = {3'b0, mq_q[62:33]}; mul_b = ad_q[k_q]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // One digit of the integer square root
  always_comb begin
    srem_s = {srem_q, sv_q[65:64]};
    strial = {3'b0, r_q, 2'b01};
    sge    = srem_s >= strial;
    srem_n = sge ? srem_s - strial : srem_s;
  end

  // Divider feed: force numerator over r^3, or |q_i q_j| over r
  always_comb begin
    div_start = (state_q == P_MULN && cnt_q == 6'd3) ||
                (state_q == P_DIVF && div_done && k_q == 2'd2);
    if (state_q == P_MULN) begin
      div_num = {num_q, 16'b0};
      div_den = r3_q;
    end else begin
      div_num = {49'b0, mq_q};
      div_den = {66'b0, r_q};
    end
  end

  // Clamp and sign of a force component, sign of the energy term
  always_comb begin
    fovf = |div_quo[cpfe_pkg::DIV_NW-1:63];
    fmag = fovf ? cpfe_pkg::POS_MAX : div_quo[63:0];
    fval = (neg_q_q ^ dneg_q[k_q]) ? -fmag : fmag;
    emag = neg_q_q ? -div_quo[63:0] : div_quo[63:0];
  end

  cpfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        P_IDLE: begin
          if (start_i) begin
            res_q   <= '0;
            cnt_q   <= '0;
            state_q <= P_MULA;
          end
        end
        P_MULA: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd4) state_q <= P_CHK;
        end
        P_CHK: begin
          cnt_q <= '0;
          if (d2_q == '0) begin
            // coincident particles: no force, no energy
            res_q.skip <= 1'b1;
            done_q     <= 1'b1;
            state_q    <= P_IDLE;
          end else begin
            state_q <= P_SQRT;
          end
        end
        P_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == SQRT_STEPS - 6'd1) begin
            cnt_q   <= '0;
            state_q <= P_MULB;
          end
        end
        P_MULB: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd4) begin
            cnt_q   <= '0;
            k_q     <= '0;
            state_q <= P_MULN;
          end
        end
        P_MULN: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) state_q <= P_DIVF;
        end
        P_DIVF: begin
          if (div_done) begin
            case (k_q)
              2'd0:    res_q.force_x <= fval;
              2'd1:    res_q.force_y <= fval;
              default: res_q.force_z <= fval;
            endcase
            res_q.sat <= res_q.sat | fovf;
            if (k_q == 2'd2) begin
              state_q <= P_DIVE;
            end else begin
              k_q     <= k_q + 2'd1;
              cnt_q   <= '0;
              state_q <= P_MULN;
            end
          end
        end
        P_DIVE: begin
          if (div_done) begin
            res_q.energy <= emag;
            done_q       <= 1'b1;
            state_q      <= P_IDLE;
          end
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
    case (state_q)
      P_IDLE: begin
        if (start_i) begin
          qa_q    <= qa_abs;
          qb_q    <= qb_abs;
          ad_q[0] <= dx[32] ? -dx : dx;
          ad_q[1] <= dy[32] ? -dy : dy;
          ad_q[2] <= dz[32] ? -dz : dz;
          dneg_q  <= {dz[32], dy[32], dx[32]};
          neg_q_q <= pi_i.charge[31] ^ pj_i.charge[31];
        end
      end
      P_MULA: begin
        case (cnt_q) inside
          6'd1:       mq_q <= mul_p_q[62:0];
          6'd2:       d2_q <= mul_p_q;
          6'd3, 6'd4: d2_q <= d2_q + mul_p_q;
          default: ;
        endcase
      end
      P_CHK: begin
        sv_q   <= d2_q;
        srem_q <= '0;
        r_q    <= '0;
      end
      P_SQRT: begin
        srem_q <= srem_n[35:0];
        r_q    <= {r_q[31:0], sge};
        sv_q   <= {sv_q[63:0], 2'b00};
      end
      P_MULB: begin
        case (cnt_q)
          6'd1: r2_q <= mul_p_q;
          6'd3: r3_q <= 99'(mul_p_q);
          6'd4: r3_q <= r3_q + {mul_p_q, 33'b0};
          default: ;
        endcase
      end
      P_MULN: begin
        case (cnt_q)
          6'd1: num_q <= 96'(mul_p_q);
          6'd2: num_q <= num_q + {mul_p_q[62:0], 33'b0};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/coulomb_pairwise_force_energy.sv =====
// Top level: particle and force memories, pair walk and command handling.
//
//  channel   signals                               direction
//  command   start, busy, cmd_i                    in  (beat when start & !busy)
//  result    done_o, res_o                         out (one-cycle beat on done_o)
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i  in  (beat when valid & ready)
//
// Load and read can follow back to back; a read's result appears in the
// cycle after it is taken (registered force memory read).
// Compute holds busy while it clears the force memory, then while it walks
// the rows and pairs; the time of a pair is set by the bit-serial divider
// (run for three force components and the energy) and the sqrt, both skipped for a coincident pair.
// Reset clears control, energy and flag, then runs the same force memory
// clear with busy high; the particle memory is undefined.
// The result side cannot stall.
module coulomb_pairwise_force_energy #(
  parameter int unsigned PARTICLES_MAX = cpfe_pkg::PARTICLES_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cpfe_pkg::cmd_t cmd_i,
  output logic           done_o,
  output cpfe_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [10:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(PARTICLES_MAX);
  localparam int unsigned NW = $clog2(PARTICLES_MAX + 1);
  localparam logic [NW-1:0] N_MAX     = NW'(PARTICLES_MAX);
  localparam logic [NW-1:0] LAST_SLOT = NW'(PARTICLES_MAX - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CLR, S_ROW_RD, S_ROW_LD, S_PAIR_RD, S_PAIR_GO, S_PAIR_RUN, S_ROW_WB
  } state_e;

  typedef struct packed {
    logic [63:0] fx;
    logic [63:0] fy;
    logic [63:0] fz;
  } fvec_t;

  state_e      state_q;
  logic [10:0] cfg_q;
  logic [NW-1:0] n_q, i_q, j_q, clr_q, n_eff;
  logic [63:0] energy_q;
  logic        flag_q;
  logic        rd_pend_q;
  logic        rd_ok_q;
  logic [63:0] rd_energy_q;
  logic        rd_flag_q;

  cpfe_pkg::part_t pi_q;
  fvec_t           acci_q, accj_q;

  // Memories
  cpfe_pkg::part_t pmem [PARTICLES_MAX];
  fvec_t           fmem [PARTICLES_MAX];
  cpfe_pkg::part_t prd_q;
  fvec_t           frd_q;
  logic            pwe, pre, fwe, fre;
  logic [AW-1:0]   pwa, pra, fwa, fra;
  fvec_t           fwd;

  logic          accept, idx_ok;
  logic [AW-1:0] idx_addr;

  logic                pr_start, pr_done;
  cpfe_pkg::pair_res_t pr;

  logic [64:0] sxi, syi, szi, sxj, syj, szj, se;
  fvec_t       acci_n, accj_n;
  logic        upd_ovf;

  // Saturating signed add; top bit reports the clamp
  function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    logic        ovf;
    s   = a + b;
    ovf = (a[63] == b[63]) && (s[63] != a[63]);
    if (ovf) s = a[63] ? cpfe_pkg::NEG_MIN : cpfe_pkg::POS_MAX;
    return {ovf, s};
  endfunction

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign idx_ok      = 32'(cmd_i.index) < 32'(PARTICLES_MAX);
  assign idx_addr    = AW'(cmd_i.index);
  assign n_eff       = (32'(cfg_q) > 32'(PARTICLES_MAX)) ? N_MAX : NW'(cfg_q);
  assign pr_start    = (state_q == S_PAIR_GO);

  // Accumulator updates of one pair
  always_comb begin
    sxi = sat_add(acci_q.fx, pr.force_x);
    syi = sat_add(acci_q.fy, pr.force_y);
    szi = sat_add(acci_q.fz, pr.force_z);
    sxj = sat_add(accj_q.fx, -pr.force_x);
    syj = sat_add(accj_q.fy, -pr.force_y);
    szj = sat_add(accj_q.fz, -pr.force_z);
    se  = sat_add(energy_q, pr.energy);
    acci_n  = {sxi[63:0], syi[63:0], szi[63:0]};
    accj_n  = {sxj[63:0], syj[63:0], szj[63:0]};
    upd_ovf = sxi[64] | syi[64] | szi[64] | sxj[64] | syj[64] | szj[64] | se[64];
  end

  // Memory port select
  always_comb begin
    pwe = accept && (cmd_i.command == cpfe_pkg::CMD_LOAD) && idx_ok;
    pwa = idx_addr;
    pre = (state_q == S_ROW_RD) || (state_q == S_PAIR_RD);
    pra = (state_q == S_ROW_RD) ? i_q[AW-1:0] : j_q[AW-1:0];
    fwe = 1'b0;
    fwa = clr_q[AW-1:0];
    fwd = '0;
    fre = 1'b0;
    fra = idx_addr;
    unique case (state_q)
      S_IDLE:   fre = accept && (cmd_i.command == cpfe_pkg::CMD_READ);
      S_CLR:    fwe = 1'b1;
      S_ROW_RD: begin fre = 1'b1; fra = i_q[AW-1:0]; end
      S_PAIR_RD: begin fre = 1'b1; fra = j_q[AW-1:0]; end
      S_PAIR_RUN: begin
        fwe = pr_done;
        fwa = j_q[AW-1:0];
        fwd = pr.skip ? accj_q : accj_n;
      end
      S_ROW_WB: begin
        fwe = 1'b1;
        fwa = i_q[AW-1:0];
        fwd = acci_q;
      end
      default: ;
    endcase
  end

  // Particle memory
  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwa] <= {cmd_i.charge, cmd_i.pos_x, cmd_i.pos_y, cmd_i.pos_z};
    if (pre) prd_q <= pmem[pra];
  end

  // Force memory
  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fwa] <= fwd;
    if (fre) frd_q <= fmem[fra];
  end

  cpfe_pair u_pair (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pr_start),
    .pi_i    (pi_q),
    .pj_i    (prd_q),
    .done_o  (pr_done),
    .res_o   (pr)
  );

  // Control: clear sweep, then rows i and pairs j > i
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // force memory starts zeroed: sweep it once after reset
      state_q   <= S_CLR;
      cfg_q     <= '0;
      n_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      clr_q     <= '0;
      energy_q  <= '0;
      flag_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      rd_pend_q <= accept && (cmd_i.command == cpfe_pkg::CMD_READ);
      unique case (state_q)
        S_IDLE: begin
          if (accept && cmd_i.command == cpfe_pkg::CMD_COMPUTE) begin
            energy_q <= '0;
            flag_q   <= 1'b0;
            clr_q    <= '0;
            n_q      <= n_eff;
            state_q  <= S_CLR;
          end
        end
        S_CLR: begin
          clr_q <= clr_q + NW'(1);
          if (clr_q == LAST_SLOT) begin
            i_q     <= '0;
            state_q <= (n_q >= NW'(2)) ? S_ROW_RD : S_IDLE;
          end
        end
        S_ROW_RD: state_q <= S_ROW_LD;
        S_ROW_LD: begin
          j_q     <= i_q + NW'(1);
          state_q <= S_PAIR_RD;
        end
        S_PAIR_RD: state_q <= S_PAIR_GO;
        S_PAIR_GO: state_q <= S_PAIR_RUN;
        S_PAIR_RUN: begin
          if (pr_done) begin
            if (pr.skip) begin
              flag_q <= 1'b1;
            end else begin
              energy_q <= se[63:0];
              flag_q   <= flag_q | pr.sat | upd_ovf;
            end
            if (j_q == n_q - NW'(1)) begin
              state_q <= S_ROW_WB;
            end else begin
              j_q     <= j_q + NW'(1);
              state_q <= S_PAIR_RD;
            end
          end
        end
        S_ROW_WB: begin
          if (i_q == n_q - NW'(2)) begin
            state_q <= S_IDLE;
          end else begin
            i_q     <= i_q + NW'(1);
            state_q <= S_ROW_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Row and pair operands, read beat capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_ok_q     <= idx_ok;
      rd_energy_q <= energy_q;
      rd_flag_q   <= flag_q;
    end
    if (state_q == S_ROW_LD) begin
      pi_q   <= prd_q;
      acci_q <= frd_q;
    end
    if (state_q == S_PAIR_GO) accj_q <= frd_q;
    if (state_q == S_PAIR_RUN && pr_done && !pr.skip) acci_q <= acci_n;
  end

  // Result beat
  assign done_o        = rd_pend_q;
  assign res_o.force_x = rd_ok_q ? frd_q.fx : '0;
  assign res_o.force_y = rd_ok_q ? frd_q.fy : '0;
  assign res_o.force_z = rd_ok_q ? frd_q.fz : '0;
  assign res_o.energy  = rd_energy_q;
  assign res_o.flagged = rd_flag_q;

endmodule
